/* rtl/core/assert_macros.svh */
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Condition that must hold at every edge, also during reset.
`define ASSERT_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) (cond)) else $error("assertion failed");
`endif

/* rtl/core/edf_pkg.sv */
// ----------------------------------------------------------------------------
// EDF dispatcher package
// Shared types, constants and commands of the job dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none
package edf_pkg;
  localparam int unsigned TaskSlotsDef  = 16;
  localparam int unsigned QueueDepthDef = 32;
  localparam int unsigned TimeBitsDef   = 32;

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdStart = 2'd1,
    CmdTick  = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  localparam logic CfgTaskCount = 1'b0;
  localparam logic CfgHorizon   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // register the input item
    logic do_load;     // write the task tables
    logic do_start;    // clear state
    logic clr_scan;    // reset the scan counter and the full flag
    logic task_rd;     // load the head job read from the queue
    logic task_eval;   // scan: evaluate task entry
    logic ins_step;    // insert: examine one queue slot
    logic pop;         // move head job to the processor
    logic run;         // advance time and the running job
    logic refuse;      // tick refused
    logic out_load;    // load result register
  } cmd_t;

  typedef struct packed {
    logic tick_ok;     // tick may run
    logic scan_last;   // last task entry
    logic release_hit; // current task entry releases a job
    logic ins_done;    // insert position found or written
    logic can_pop;     // processor free and queue not empty
  } sts_t;
endpackage
`default_nettype wire

/* rtl/core/edf_datapath.sv */
// ----------------------------------------------------------------------------
// EDF dispatcher datapath
// Task tables, sorted ready queue in memory, running job and time.
// ----------------------------------------------------------------------------
`default_nettype none
module edf_datapath import edf_pkg::*; #(
  parameter int unsigned TaskSlots  = TaskSlotsDef,
  parameter int unsigned QueueDepth = QueueDepthDef,
  parameter int unsigned TimeBits   = TimeBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [3:0]  task_index_i,
  input  wire logic [15:0] period_i,
  input  wire logic [15:0] exec_time_i,
  output logic [3:0]       running_task_o,
  output logic             idle_o,
  output logic             job_done_o,
  output logic             deadline_miss_o,
  output logic             queue_full_o,
  output logic             finished_o,
  output logic [31:0]      current_time_o
);
  localparam int unsigned TW = (TaskSlots > 1) ? $clog2(TaskSlots) : 1;
  localparam int unsigned QW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam int unsigned NW = $clog2(TaskSlots + 1);
  localparam int unsigned HW = (TimeBits > 32) ? TimeBits : 32;
  localparam logic [TimeBits-1:0] TimeMax = '1;

  // Ready queue entry: deadline, task, remaining.
  localparam int unsigned EW = TimeBits + TW + 16;

  logic [4:0]  task_count_q;
  logic [31:0] horizon_q;
  logic [3:0]  idx_q;
  logic [15:0] per_q, exe_q;

  logic [15:0]         per_tab_q [TaskSlots];
  logic [15:0]         exe_tab_q [TaskSlots];
  logic [TimeBits-1:0] nrel_q    [TaskSlots];

  logic [EW-1:0] qmem [QueueDepth];
  logic [EW-1:0] qrd_q;
  logic [CW-1:0] count_q;

  logic [TW-1:0]       scan_q;
  logic [CW-1:0]       ipos_q;
  logic                ins_act_q;
  logic                ins_ph_q;
  logic [EW-1:0]       new_q;
  logic                full_q;

  logic                cur_valid_q, halted_q;
  logic [TW-1:0]       cur_task_q;
  logic [TimeBits-1:0] cur_dl_q, now_q;
  logic [15:0]         cur_rem_q;

  // Pop compaction: shift entries 1..count-1 down by one, one per cycle.
  logic [CW-1:0] sh_q;
  logic          sh_act_q;
  logic          sh_wv_q;
  logic [QW-1:0] sh_wa_q;
  logic [EW-1:0] sh_rd_q;

  logic [NW-1:0] n_lim;
  always_comb begin
    if ({27'd0, task_count_q} > TaskSlots) n_lim = NW'(TaskSlots);
    else n_lim = NW'(task_count_q);
  end

  logic [15:0]         t_per, t_exe;
  logic [TimeBits-1:0] t_nrel;
  logic [TimeBits:0]   dl_sum;
  logic [TimeBits-1:0] dl_sat;
  assign t_per  = per_tab_q[scan_q];
  assign t_exe  = exe_tab_q[scan_q];
  assign t_nrel = nrel_q[scan_q];
  assign dl_sum = {1'b0, now_q} + {{(TimeBits-15){1'b0}}, t_per};
  assign dl_sat = dl_sum[TimeBits] ? TimeMax : dl_sum[TimeBits-1:0];

  logic scan_in;
  assign scan_in = (NW'(scan_q) < n_lim);

  // Insertion: walk from the tail down, shifting entries up until the slot fits.
  // For each slot the entry below is read first, then compared and written.
  logic [TimeBits-1:0] rd_dl;
  logic [TW-1:0]       rd_task;
  logic                new_before;
  logic                ins_shift;
  logic                ins_wr;
  logic [EW-1:0]       ins_wdata;
  assign rd_dl   = qrd_q[EW-1 -: TimeBits];
  assign rd_task = qrd_q[16 +: TW];
  assign new_before = (new_q[EW-1 -: TimeBits] < rd_dl) ||
    (new_q[EW-1 -: TimeBits] == rd_dl && new_q[16 +: TW] < rd_task);
  assign ins_shift = (ipos_q != 0) && new_before;
  assign ins_wr    = ins_act_q && cmd_i.ins_step && ins_ph_q;
  assign ins_wdata = ins_shift ? qrd_q : new_q;

  logic [TimeBits-1:0] now_inc;
  logic [15:0]         run_rem;
  assign now_inc = now_q + TimeBits'(1);
  assign run_rem = (cur_rem_q != 16'd0) ? cur_rem_q - 16'd1 : 16'd0;

  logic [QW-1:0] rd_addr;
  always_comb begin
    if (cmd_i.pop) rd_addr = '0;
    else rd_addr = QW'(ipos_q - CW'(1));
  end

  assign sts_o.tick_ok     = !halted_q && (HW'(now_q) < HW'(horizon_q));
  assign sts_o.scan_last   = !scan_in || (scan_q == TW'(TaskSlots - 1));
  assign sts_o.release_hit = scan_in && t_per != 0 && t_exe != 0 && t_nrel == now_q;
  assign sts_o.ins_done    = !ins_act_q;
  assign sts_o.can_pop     = !cur_valid_q && count_q != 0;

  always_ff @(posedge clk_i) begin
    qrd_q   <= qmem[rd_addr];
    sh_rd_q <= qmem[QW'(sh_q)];
    if (ins_wr) qmem[QW'(ipos_q)] <= ins_wdata;
    else if (sh_wv_q) qmem[sh_wa_q] <= sh_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q <= task_index_i; per_q <= period_i; exe_q <= exec_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= 5'd1; horizon_q <= '0; count_q <= '0; scan_q <= '0;
      ipos_q <= '0; ins_act_q <= 1'b0; ins_ph_q <= 1'b0; full_q <= 1'b0; cur_valid_q <= 1'b0;
      halted_q <= 1'b0; cur_task_q <= '0; cur_dl_q <= '0; cur_rem_q <= '0; now_q <= '0;
      new_q <= '0;
      sh_q <= '0; sh_act_q <= 1'b0; sh_wv_q <= 1'b0; sh_wa_q <= '0;
      for (int i = 0; i < TaskSlots; i++) begin
        per_tab_q[i] <= '0; exe_tab_q[i] <= '0; nrel_q[i] <= '0;
      end
      running_task_o <= '0; idle_o <= 1'b0; job_done_o <= 1'b0; deadline_miss_o <= 1'b0;
      queue_full_o <= 1'b0; finished_o <= 1'b0; current_time_o <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgTaskCount) task_count_q <= cfg_data_i[4:0];
        else horizon_q <= cfg_data_i;
      end
      if (cmd_i.do_load && {28'd0, idx_q} < TaskSlots) begin
        per_tab_q[TW'(idx_q)] <= per_q;
        exe_tab_q[TW'(idx_q)] <= exe_q;
        nrel_q[TW'(idx_q)]    <= now_q;
      end
      if (cmd_i.do_start) begin
        now_q <= '0; count_q <= '0; cur_valid_q <= 1'b0; cur_task_q <= '0;
        cur_dl_q <= '0; cur_rem_q <= '0; halted_q <= 1'b0;
        for (int i = 0; i < TaskSlots; i++) nrel_q[i] <= '0;
      end
      if (cmd_i.clr_scan) begin
        scan_q <= '0; full_q <= 1'b0;
      end
      if (cmd_i.task_eval) begin
        if (sts_o.release_hit) begin
          nrel_q[scan_q] <= t_nrel + {{(TimeBits-16){1'b0}}, t_per};
          if (count_q >= CW'(QueueDepth)) full_q <= 1'b1;
          else begin
            new_q <= {dl_sat, scan_q, t_exe};
            ipos_q <= count_q; ins_act_q <= 1'b1; ins_ph_q <= 1'b0;
          end
        end
        if (!sts_o.scan_last) scan_q <= scan_q + TW'(1);
      end
      if (cmd_i.ins_step && ins_act_q) begin
        if (!ins_ph_q) ins_ph_q <= 1'b1;
        else begin
          ins_ph_q <= 1'b0;
          if (ins_shift) ipos_q <= ipos_q - CW'(1);
          else begin
            ins_act_q <= 1'b0; count_q <= count_q + CW'(1);
          end
        end
      end
      if (cmd_i.pop) begin
        cur_valid_q <= 1'b1;
        sh_q <= CW'(1); sh_act_q <= 1'b1; sh_wv_q <= 1'b0;
      end else if (sh_act_q) begin
        sh_wv_q <= (sh_q < count_q);
        sh_wa_q <= QW'(sh_q - CW'(1));
        if (sh_q >= count_q) begin
          sh_act_q <= 1'b0; count_q <= count_q - CW'(1);
        end else sh_q <= sh_q + CW'(1);
      end else begin
        sh_wv_q <= 1'b0;
      end
      if (cmd_i.run) begin
        now_q <= now_inc;
        running_task_o <= cur_valid_q ? 4'(cur_task_q) : 4'd0;
        idle_o <= !cur_valid_q;
        job_done_o <= cur_valid_q && (run_rem == 16'd0);
        deadline_miss_o <= cur_valid_q && (run_rem != 16'd0) && (now_inc > cur_dl_q);
        if (cur_valid_q) begin
          cur_rem_q <= run_rem;
          if (run_rem == 16'd0) cur_valid_q <= 1'b0;
          else if (now_inc > cur_dl_q) halted_q <= 1'b1;
        end
        queue_full_o <= full_q; finished_o <= 1'b0;
        current_time_o <= 32'(now_inc);
      end
      if (cmd_i.refuse) begin
        running_task_o <= '0; idle_o <= 1'b0; job_done_o <= 1'b0;
        deadline_miss_o <= 1'b0; queue_full_o <= 1'b0; finished_o <= 1'b1;
        current_time_o <= 32'(now_q);
      end
      if (cmd_i.out_load) begin
        running_task_o <= '0; idle_o <= 1'b0; job_done_o <= 1'b0;
        deadline_miss_o <= 1'b0; queue_full_o <= 1'b0; finished_o <= 1'b0;
        current_time_o <= cmd_i.do_start ? 32'd0 : 32'(now_q);
      end
      if (cmd_i.task_rd) begin
        // Head job was read in the previous cycle into qrd_q.
        cur_task_q <= qrd_q[16 +: TW];
        cur_dl_q   <= qrd_q[EW-1 -: TimeBits];
        cur_rem_q  <= qrd_q[15:0];
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/edf_controller.sv */
// ----------------------------------------------------------------------------
// EDF dispatcher controller
// Sequences load, start and tick commands over the datapath; other commands give an empty result.
// ----------------------------------------------------------------------------
`default_nettype none
module edf_controller import edf_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire logic [1:0] command_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o
);
  localparam int unsigned SW = $clog2(QueueDepth + 2) + 1;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDec   = 9'b000000010,
    StScan  = 9'b000000100,
    StIns   = 9'b000001000,
    StPopRd = 9'b000010000,
    StPopWt = 9'b000100000,
    StShift = 9'b001000000,
    StRun   = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] cmd_q;
  logic [SW-1:0] wait_q;
  logic out_valid_q, out_set;

  assign in_stall  = (state_q != StIdle) || (out_valid_q && out_stall);
  assign out_valid = out_valid_q;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    out_set = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid && !in_stall) begin
          cmd_o.capture = 1'b1; state_d = StDec;
        end
      end
      StDec: begin
        unique case (cmd_e'(cmd_q))
          CmdLoad: begin
            cmd_o.do_load = 1'b1; cmd_o.out_load = 1'b1; out_set = 1'b1; state_d = StIdle;
          end
          CmdStart: begin
            cmd_o.do_start = 1'b1; cmd_o.out_load = 1'b1; out_set = 1'b1; state_d = StIdle;
          end
          CmdTick: begin
            if (sts_i.tick_ok) begin
              cmd_o.clr_scan = 1'b1; state_d = StScan;
            end else begin
              cmd_o.refuse = 1'b1; out_set = 1'b1; state_d = StIdle;
            end
          end
          default: begin
            cmd_o.out_load = 1'b1; out_set = 1'b1; state_d = StIdle;
          end
        endcase
      end
      StScan: begin
        cmd_o.task_eval = 1'b1;
        if (sts_i.release_hit) state_d = StIns;
        else if (sts_i.scan_last) state_d = StPopRd;
      end
      StIns: begin
        cmd_o.ins_step = 1'b1;
        if (sts_i.ins_done) state_d = StScan;
      end
      StPopRd: begin
        if (sts_i.can_pop) begin
          cmd_o.pop = 1'b1; state_d = StPopWt;
        end else state_d = StRun;
      end
      StPopWt: begin
        cmd_o.task_rd = 1'b1; state_d = StShift;
      end
      StShift: begin
        if (wait_q == '0) state_d = StRun;
      end
      StRun: begin
        cmd_o.run = 1'b1; out_set = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cmd_q <= '0; out_valid_q <= 1'b0; wait_q <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_o.capture) cmd_q <= command_i;
      if (cmd_o.pop) wait_q <= SW'(QueueDepth + 1);
      else if (wait_q != 0) wait_q <= wait_q - SW'(1);
      if (out_set) out_valid_q <= 1'b1;
      else if (!out_stall) out_valid_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/edf_job_dispatcher.sv */
// A load, start, unknown command or refused tick gives its result from the decode
// state. A tick scans the task entries, inserts each released job into the sorted
// queue (dropped when full), takes the head job when the processor is free, waits
// for the queue compaction and runs one time step. Throughput: one item at a time;
// a new transfer is taken once the controller is idle and no result is stalled.
// Reset: asynchronous, active low; tables, time and queue clear, task_count 1, horizon 0.
// ----------------------------------------------------------------------------
// EDF job dispatcher
// Non-preemptive earliest-deadline-first dispatcher for periodic tasks.
// ----------------------------------------------------------------------------
`default_nettype none
module edf_job_dispatcher import edf_pkg::*; #(
  parameter int unsigned TASK_SLOTS  = TaskSlotsDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command_i,
  input  wire logic [3:0]  task_index_i,
  input  wire logic [15:0] period_i,
  input  wire logic [15:0] exec_time_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       running_task_o,
  output logic             idle_o,
  output logic             job_done_o,
  output logic             deadline_miss_o,
  output logic             queue_full_o,
  output logic             finished_o,
  output logic [31:0]      current_time_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  assign cfg_ready = 1'b1;

  edf_controller #(.QueueDepth(QUEUE_DEPTH)) u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .command_i, .sts_i(sts), .cmd_o(cmd)
  );

  edf_datapath #(.TaskSlots(TASK_SLOTS), .QueueDepth(QUEUE_DEPTH), .TimeBits(TIME_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_valid_i(cfg_valid),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data), .task_index_i, .period_i,
    .exec_time_i, .running_task_o, .idle_o, .job_done_o, .deadline_miss_o, .queue_full_o,
    .finished_o, .current_time_o
  );
endmodule
`default_nettype wire

/* rtl/core/edf_checker.sv */
// ----------------------------------------------------------------------------
// EDF dispatcher checker
// Port-level properties of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module edf_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic idle_o,
  input wire logic job_done_o,
  input wire logic deadline_miss_o,
  input wire logic finished_o
);
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid && out_stall |=> out_valid)
  `ASSERT_IMPL(a_busy_after_take, clk_i, rst_ni, in_valid && !in_stall |=> in_stall)
  `ASSERT_IMPL(a_fin_excl, clk_i, rst_ni, out_valid && finished_o |-> !idle_o && !job_done_o)
  `ASSERT_IMPL(a_idle_excl, clk_i, rst_ni, out_valid && idle_o |-> !job_done_o && !deadline_miss_o)
endmodule
bind edf_job_dispatcher edf_checker u_chk (.*);
`default_nettype wire
